>>> design/bamb_pkg.sv
package bamb_pkg;

  // magnitude of a divider numerator, up to the 2^50 clamp
  localparam int unsigned NUM_W   = 51;
  // divisor: r^2 + x^2, t^2 (t up to 2^28) or t
  localparam int unsigned DEN_W   = 57;
  // signed intermediate admittance values
  localparam int unsigned VAL_W   = 52;
  // extra quotient bits past the integer part, up to 2 * 28
  localparam int unsigned SHIFT_W = 6;
  // effective tap ratio, wide enough for 1.0 at the largest fraction width
  localparam int unsigned TAP_W   = 29;

  localparam logic [VAL_W-1:0] CAP = 52'h4000000000000;

  typedef struct packed {
    logic               start;
    logic               neg;
    logic [NUM_W-1:0]   num;
    logic [DEN_W-1:0]   den;
    logic [SHIFT_W-1:0] shift;
  } div_req_t;

  typedef struct packed {
    logic                    done;
    logic                    sat;
    logic signed [VAL_W-1:0] quot;
  } div_rsp_t;

endpackage

>>> design/bus_admittance_matrix_builder.sv
// Bus admittance matrix builder. Keeps a BUS_COUNT x BUS_COUNT complex matrix (Q20.20
// conductance and susceptance) in two synchronous RAMs. An add beat brings one branch; the
// block forms y = 1/(R+jX) and adds (y+jB)/t^2, -y/t, -y/t and y+jB to the from diagonal, the
// two off-diagonals and the to diagonal, in that order, with saturating adds. A read beat
// returns one entry, a clear beat zeroes the store. One item is worked on at a time; the next
// input beat is taken as soon as the result sits in the output register. A clear writes one
// entry per cycle. An add runs the two restoring dividers, one quotient bit per cycle, in
// three rounds: conductance and susceptance, the diagonal scale by t^2, the off-diagonal
// scale by t. After reset the store is swept to zero while the input is stalled.
module bus_admittance_matrix_builder #(
  parameter int unsigned BUS_COUNT = 64,
  parameter int unsigned FRAC_BITS = 20
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         mode_i,
  input  logic [6:0]         from_bus_i,
  input  logic [6:0]         to_bus_i,
  input  logic [23:0]        resistance_i,
  input  logic signed [23:0] reactance_i,
  input  logic signed [23:0] shunt_susceptance_i,
  input  logic [21:0]        tap_ratio_i,
  input  logic [6:0]         row_bus_i,
  input  logic [6:0]         col_bus_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [39:0] real_part_o,
  output logic signed [39:0] imag_part_o,
  output logic [1:0]         status_o
);

  import bamb_pkg::*;

  localparam int unsigned DEPTH = BUS_COUNT * BUS_COUNT;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned LIN_W = AW + 7;
  localparam int unsigned SUM_W = VAL_W + 1;

  localparam logic [1:0] MODE_ADD   = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_ZERO_Z = 2'd1;
  localparam logic [1:0] STAT_RANGE  = 2'd2;
  localparam logic [1:0] STAT_SAT    = 2'd3;

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_RDW  = 4'd2;
  localparam logic [3:0] S_MR   = 4'd3;
  localparam logic [3:0] S_MX   = 4'd4;
  localparam logic [3:0] S_MT   = 4'd5;
  localparam logic [3:0] S_DG   = 4'd6;
  localparam logic [3:0] S_WG   = 4'd7;
  localparam logic [3:0] S_YS   = 4'd8;
  localparam logic [3:0] S_DII  = 4'd9;
  localparam logic [3:0] S_WII  = 4'd10;
  localparam logic [3:0] S_DOF  = 4'd11;
  localparam logic [3:0] S_WOF  = 4'd12;
  localparam logic [3:0] S_ARD  = 4'd13;
  localparam logic [3:0] S_AWR  = 4'd14;
  localparam logic [3:0] S_DONE = 4'd15;

  localparam logic [TAP_W-1:0]       TAP_ONE = TAP_W'(1) << FRAC_BITS;
  localparam logic signed [SUM_W-1:0] CAP_POS = $signed({1'b0, CAP});
  localparam logic signed [SUM_W-1:0] CAP_NEG = -CAP_POS;
  localparam logic signed [SUM_W-1:0] E_MAX   = SUM_W'(40'sh7F_FFFF_FFFF);
  localparam logic signed [SUM_W-1:0] E_MIN   = SUM_W'(40'sh80_0000_0000);

  function automatic logic bus_ok(input logic [6:0] b);
    return (b != 7'd0) && (32'(b) <= BUS_COUNT);
  endfunction

  // row-major entry address from one-based bus numbers
  function automatic logic [AW-1:0] lin_idx(input logic [6:0] r, input logic [6:0] c);
    logic [6:0]       rm;
    logic [6:0]       cm;
    logic [LIN_W-1:0] lin;
    rm  = r - 7'd1;
    cm  = c - 7'd1;
    lin = LIN_W'(rm) * LIN_W'(BUS_COUNT) + LIN_W'(cm);
    return lin[AW-1:0];
  endfunction

  function automatic logic [NUM_W-1:0] mag_of(input logic signed [VAL_W-1:0] v);
    logic [VAL_W-1:0] a;
    a = v[VAL_W-1] ? VAL_W'(-v) : VAL_W'(v);
    return a[NUM_W-1:0];
  endfunction

  // control
  logic [3:0]    state_q, state_d;
  logic [AW-1:0] clr_cnt_q, clr_cnt_d;
  logic          clr_item_q, clr_item_d;
  logic [1:0]    step_q, step_d;
  logic          out_valid_q, out_valid_d;

  // item fields and intermediates
  logic [23:0]               r_q;
  logic signed [23:0]        x_q;
  logic signed [23:0]        bsh_q;
  logic [TAP_W-1:0]          t_q;
  logic [6:0]                ib_q;
  logic [6:0]                jb_q;
  logic [2*TAP_W-1:0]        prod_q;
  logic [DEN_W-1:0]          d_q;
  logic [DEN_W-1:0]          t2_q;
  logic signed [VAL_W-1:0]   g_q, b_q, ysi_q;
  logic signed [VAL_W-1:0]   iire_q, iiim_q, ofre_q, ofim_q;
  logic                      sat_q;
  logic [39:0]               res_re_q, res_im_q;
  logic [1:0]                res_st_q;
  logic [39:0]               out_re_q, out_im_q;
  logic [1:0]                out_st_q;

  logic              accept;
  logic              out_free;
  logic [1:0]        st_in;
  logic [TAP_W-1:0]  tap_eff;
  logic [23:0]       xm;
  logic [TAP_W-1:0]  mul_a, mul_b;
  logic signed [SUM_W-1:0] ysum;
  logic signed [VAL_W-1:0] ysi_d;
  logic              ys_sat;
  logic [6:0]        acc_row, acc_col;
  logic [AW-1:0]     acc_addr;
  logic signed [VAL_W-1:0] val_re, val_im;
  logic signed [SUM_W-1:0] acc_re, acc_im;
  logic [39:0]       wd_re, wd_im;
  logic              acc_sat;

  // memory ports
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  logic [39:0]   mem_wre, mem_wim;
  logic [39:0]   rd_re, rd_im;

  div_req_t req0, req1;
  div_rsp_t rsp0, rsp1;

  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign tap_eff    = (tap_ratio_i == 22'd0) ? TAP_ONE : TAP_W'(tap_ratio_i);
  assign xm         = x_q[23] ? 24'(-x_q) : 24'(x_q);

  // status known at accept; an add that goes on gets its status at the last write
  always_comb begin
    st_in = STAT_OK;
    if (mode_i == MODE_ADD) begin
      if (!bus_ok(from_bus_i) || !bus_ok(to_bus_i)) begin
        st_in = STAT_RANGE;
      end else if (resistance_i == 24'd0 && reactance_i == 24'sd0) begin
        st_in = STAT_ZERO_Z;
      end
    end else if (mode_i == MODE_READ) begin
      if (!bus_ok(row_bus_i) || !bus_ok(col_bus_i)) begin
        st_in = STAT_RANGE;
      end
    end
  end

  // one shared multiplier: r^2, x^2, then t^2
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_MR: begin
        mul_a = TAP_W'(r_q);
        mul_b = TAP_W'(r_q);
      end
      S_MX: begin
        mul_a = TAP_W'(xm);
        mul_b = TAP_W'(xm);
      end
      S_MT: begin
        mul_a = t_q;
        mul_b = t_q;
      end
      default: ;
    endcase
  end

  // shunt susceptance joins b, clamped at +-2^50
  always_comb begin
    ysum   = SUM_W'(b_q) + SUM_W'(bsh_q);
    ys_sat = 1'b0;
    if (ysum > CAP_POS) begin
      ysi_d  = VAL_W'(CAP_POS);
      ys_sat = 1'b1;
    end else if (ysum < CAP_NEG) begin
      ysi_d  = VAL_W'(CAP_NEG);
      ys_sat = 1'b1;
    end else begin
      ysi_d = VAL_W'(ysum);
    end
  end

  // divider rounds
  always_comb begin
    req0 = '0;
    req1 = '0;
    case (state_q)
      S_DG: begin
        req0.start = 1'b1;
        req0.neg   = 1'b0;
        req0.num   = NUM_W'(r_q);
        req0.den   = d_q;
        req0.shift = SHIFT_W'(2 * FRAC_BITS);
        req1.start = 1'b1;
        req1.neg   = ~x_q[23];
        req1.num   = NUM_W'(xm);
        req1.den   = d_q;
        req1.shift = SHIFT_W'(2 * FRAC_BITS);
      end
      S_DII: begin
        req0.start = 1'b1;
        req0.neg   = 1'b0;
        req0.num   = mag_of(g_q);
        req0.den   = t2_q;
        req0.shift = SHIFT_W'(2 * FRAC_BITS);
        req1.start = 1'b1;
        req1.neg   = ysi_q[VAL_W-1];
        req1.num   = mag_of(ysi_q);
        req1.den   = t2_q;
        req1.shift = SHIFT_W'(2 * FRAC_BITS);
      end
      S_DOF: begin
        // off-diagonals carry the negated quotient
        req0.start = 1'b1;
        req0.neg   = 1'b1;
        req0.num   = mag_of(g_q);
        req0.den   = DEN_W'(t_q);
        req0.shift = SHIFT_W'(FRAC_BITS);
        req1.start = 1'b1;
        req1.neg   = ~b_q[VAL_W-1];
        req1.num   = mag_of(b_q);
        req1.den   = DEN_W'(t_q);
        req1.shift = SHIFT_W'(FRAC_BITS);
      end
      default: ;
    endcase
  end

  // accumulation order: from diagonal, from-to, to-from, to diagonal
  always_comb begin
    acc_row = step_q[1] ? jb_q : ib_q;
    acc_col = step_q[0] ? jb_q : ib_q;
    val_re  = g_q;
    val_im  = ysi_q;
    case (step_q) inside
      2'd0: begin
        val_re = iire_q;
        val_im = iiim_q;
      end
      2'd1, 2'd2: begin
        val_re = ofre_q;
        val_im = ofim_q;
      end
      default: ;
    endcase
  end

  assign acc_addr = lin_idx(acc_row, acc_col);

  // saturating read-modify-write: each entry is read in S_ARD and written in S_AWR before the next read, so no overlap
  always_comb begin
    acc_re  = SUM_W'($signed(rd_re)) + SUM_W'(val_re);
    acc_im  = SUM_W'($signed(rd_im)) + SUM_W'(val_im);
    acc_sat = 1'b0;
    if (acc_re > E_MAX) begin
      wd_re   = E_MAX[39:0];
      acc_sat = 1'b1;
    end else if (acc_re < E_MIN) begin
      wd_re   = E_MIN[39:0];
      acc_sat = 1'b1;
    end else begin
      wd_re = acc_re[39:0];
    end
    if (acc_im > E_MAX) begin
      wd_im   = E_MAX[39:0];
      acc_sat = 1'b1;
    end else if (acc_im < E_MIN) begin
      wd_im   = E_MIN[39:0];
      acc_sat = 1'b1;
    end else begin
      wd_im = acc_im[39:0];
    end
  end

  assign mem_we    = (state_q == S_CLR) || (state_q == S_AWR);
  assign mem_waddr = (state_q == S_CLR) ? clr_cnt_q : acc_addr;
  assign mem_wre   = (state_q == S_CLR) ? 40'd0 : wd_re;
  assign mem_wim   = (state_q == S_CLR) ? 40'd0 : wd_im;
  assign mem_raddr = (state_q == S_IDLE) ? lin_idx(row_bus_i, col_bus_i) : acc_addr;

  // sequencer
  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    clr_item_d  = clr_item_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_CLR: begin
        if (clr_cnt_q == AW'(DEPTH - 1)) begin
          clr_cnt_d  = '0;
          clr_item_d = 1'b0;
          state_d    = clr_item_q ? S_DONE : S_IDLE;
        end else begin
          clr_cnt_d = clr_cnt_q + AW'(1);
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (mode_i)
            MODE_ADD:   state_d = (st_in == STAT_OK) ? S_MR : S_DONE;
            MODE_READ:  state_d = (st_in == STAT_OK) ? S_RDW : S_DONE;
            MODE_CLEAR: begin
              clr_item_d = 1'b1;
              clr_cnt_d  = '0;
              state_d    = S_CLR;
            end
            default:    state_d = S_DONE;
          endcase
        end
      end
      S_RDW: state_d = S_DONE;
      S_MR:  state_d = S_MX;
      S_MX:  state_d = S_MT;
      S_MT:  state_d = S_DG;
      S_DG:  state_d = S_WG;
      S_WG:  if (rsp0.done) state_d = S_YS;
      S_YS:  state_d = S_DII;
      S_DII: state_d = S_WII;
      S_WII: if (rsp0.done) state_d = S_DOF;
      S_DOF: state_d = S_WOF;
      S_WOF: begin
        if (rsp0.done) begin
          step_d  = 2'd0;
          state_d = S_ARD;
        end
      end
      S_ARD: state_d = S_AWR;
      S_AWR: begin
        step_d  = step_q + 2'd1;
        state_d = (step_q == 2'd3) ? S_DONE : S_ARD;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_cnt_q   <= '0;
      clr_item_q  <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      clr_item_q  <= clr_item_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          r_q      <= resistance_i;
          x_q      <= reactance_i;
          bsh_q    <= shunt_susceptance_i;
          t_q      <= tap_eff;
          ib_q     <= from_bus_i;
          jb_q     <= to_bus_i;
          sat_q    <= 1'b0;
          res_re_q <= '0;
          res_im_q <= '0;
          res_st_q <= st_in;
        end
      end
      S_RDW: begin
        res_re_q <= rd_re;
        res_im_q <= rd_im;
      end
      S_MX: d_q  <= DEN_W'(prod_q);
      S_MT: d_q  <= d_q + DEN_W'(prod_q);
      S_DG: t2_q <= DEN_W'(prod_q);
      S_WG: begin
        if (rsp0.done) begin
          g_q   <= rsp0.quot;
          b_q   <= rsp1.quot;
          sat_q <= sat_q | rsp0.sat | rsp1.sat;
        end
      end
      S_YS: begin
        ysi_q <= ysi_d;
        sat_q <= sat_q | ys_sat;
      end
      S_WII: begin
        if (rsp0.done) begin
          iire_q <= rsp0.quot;
          iiim_q <= rsp1.quot;
          sat_q  <= sat_q | rsp0.sat | rsp1.sat;
        end
      end
      S_WOF: begin
        if (rsp0.done) begin
          ofre_q <= rsp0.quot;
          ofim_q <= rsp1.quot;
          sat_q  <= sat_q | rsp0.sat | rsp1.sat;
        end
      end
      S_AWR: begin
        sat_q <= sat_q | acc_sat;
        if (step_q == 2'd3) begin
          res_st_q <= (sat_q || acc_sat) ? STAT_SAT : STAT_OK;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_re_q <= res_re_q;
          out_im_q <= res_im_q;
          out_st_q <= res_st_q;
        end
      end
      default: ;
    endcase
  end

  bamb_div u_div_re (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req0),
    .rsp_o  (rsp0)
  );

  bamb_div u_div_im (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req1),
    .rsp_o  (rsp1)
  );

  bamb_ram #(
    .WIDTH (40),
    .DEPTH (DEPTH)
  ) u_ram_re (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wre),
    .raddr_i (mem_raddr),
    .rdata_o (rd_re)
  );

  bamb_ram #(
    .WIDTH (40),
    .DEPTH (DEPTH)
  ) u_ram_im (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wim),
    .raddr_i (mem_raddr),
    .rdata_o (rd_im)
  );

  assign out_valid_o = out_valid_q;
  assign real_part_o = $signed(out_re_q);
  assign imag_part_o = $signed(out_im_q);
  assign status_o    = out_st_q;

endmodule

>>> design/bamb_ram.sv
module bamb_ram #(
  parameter int unsigned WIDTH = 40,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/bamb_div.sv
module bamb_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bamb_pkg::div_req_t  req_i,
  output bamb_pkg::div_rsp_t  rsp_o
);

  import bamb_pkg::*;

  localparam int unsigned CNT_W = $clog2(NUM_W + (1 << SHIFT_W));

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             ovf_q, ovf_d;
  logic             neg_q, neg_d;
  logic [NUM_W-1:0] num_q, num_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [VAL_W-1:0] quo_q, quo_d;
  logic [DEN_W:0]   trial;
  logic             fits;
  logic             over;
  logic [VAL_W-1:0] mag;

  // restoring division, one quotient bit per cycle, numerator then zeros
  always_comb begin
    trial  = {rem_q, num_q[NUM_W-1]};
    fits   = trial >= {1'b0, den_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    ovf_d  = ovf_q;
    neg_d  = neg_q;
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(NUM_W) + CNT_W'(req_i.shift);
      ovf_d  = 1'b0;
      neg_d  = req_i.neg;
      num_d  = req_i.num;
      den_d  = req_i.den;
      rem_d  = '0;
      quo_d  = '0;
    end else if (busy_q) begin
      num_d = num_q << 1;
      rem_d = fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
      quo_d = {quo_q[VAL_W-2:0], fits};
      ovf_d = ovf_q | quo_q[VAL_W-1];
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ovf_q <= ovf_d;
    neg_q <= neg_d;
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  // clamp the magnitude at 2^50, then restore the sign
  assign over       = ovf_q || (quo_q > CAP);
  assign mag        = over ? CAP : quo_q;
  assign rsp_o.done = done_q;
  assign rsp_o.sat  = over;
  assign rsp_o.quot = neg_q ? $signed(-mag) : $signed(mag);

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps

module tb;

  typedef enum logic [1:0] {
    MODE_ADD   = 2'd0,
    MODE_READ  = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_ZERO  = 2'd1,
    ST_RANGE = 2'd2,
    ST_SAT   = 2'd3
  } status_e;

  typedef struct {
    logic signed [39:0] re;
    logic signed [39:0] im;
    logic [1:0]         st;
  } entry_beat_t;

  localparam int          BUSES       = 64;
  localparam int          FRAC        = 20;
  localparam longint      ENTRY_MAX   = 64'sd549755813887;
  localparam longint      ENTRY_MIN   = -64'sd549755813888;
  localparam longint      INTERM_CAP  = 64'sd1 << 50;
  localparam int unsigned CYCLE_LIMIT = 10000000;
  localparam int          DRAIN       = 400;

  logic clk = 1'b0;
  logic rst_ni = 1'b0;

  // input channel
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         mode_q = MODE_NONE;
  logic [6:0]         from_bus_q = '0;
  logic [6:0]         to_bus_q = '0;
  logic [23:0]        resistance_q = '0;
  logic signed [23:0] reactance_q = '0;
  logic signed [23:0] shunt_q = '0;
  logic [21:0]        tap_q = '0;
  logic [6:0]         row_bus_q = '0;
  logic [6:0]         col_bus_q = '0;

  // output channel
  logic               out_valid;
  logic               out_stall = 1'b1;
  logic signed [39:0] real_part;
  logic signed [39:0] imag_part;
  logic [1:0]         status;

  // idle percentages for the two sides, changed per phase
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  int unsigned cycles = 0;
  int unsigned errors = 0;
  int unsigned n_adds = 0, n_reads = 0, n_clears = 0, n_other = 0;
  int unsigned n_checked = 0, n_sat = 0;

  // predicted matrix contents, row-major, zero-based bus indices
  longint g_store [BUSES*BUSES];
  longint b_store [BUSES*BUSES];
  entry_beat_t pending_results[$];

  always #5 clk = ~clk;

  bus_admittance_matrix_builder uut (
    .clk_i               (clk),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall),
    .mode_i              (mode_q),
    .from_bus_i          (from_bus_q),
    .to_bus_i            (to_bus_q),
    .resistance_i        (resistance_q),
    .reactance_i         (reactance_q),
    .shunt_susceptance_i (shunt_q),
    .tap_ratio_i         (tap_q),
    .row_bus_i           (row_bus_q),
    .col_bus_i           (col_bus_q),
    .out_valid_o         (out_valid),
    .out_stall_i         (out_stall),
    .real_part_o         (real_part),
    .imag_part_o         (imag_part),
    .status_o            (status)
  );

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // floor(num * 2^k / den) on magnitudes, clamped at the intermediate cap
  function automatic longint unsigned scaled_quot(input longint unsigned num, input int k,
                                                  input longint unsigned den, inout bit sat);
    longint unsigned q, r;
    q = num / den;
    r = num % den;
    if (q > INTERM_CAP) begin
      sat = 1'b1;
      return INTERM_CAP;
    end
    for (int n = 0; n < k; n++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q = q | 64'd1;
      end
      if (q > INTERM_CAP) begin
        sat = 1'b1;
        return INTERM_CAP;
      end
    end
    return q;
  endfunction

  // same, signed: divide the magnitude, truncate toward zero, restore sign
  function automatic longint signed_quot(input longint v, input int k,
                                         input longint unsigned den, inout bit sat);
    longint unsigned mag;
    longint q;
    mag = (v < 0) ? longint'(-v) : longint'(v);
    q = longint'(scaled_quot(mag, k, den, sat));
    return (v < 0) ? -q : q;
  endfunction

  function automatic longint clamp_cap(input longint v, inout bit sat);
    if (v > INTERM_CAP) begin
      sat = 1'b1;
      return INTERM_CAP;
    end
    if (v < -INTERM_CAP) begin
      sat = 1'b1;
      return -INTERM_CAP;
    end
    return v;
  endfunction

  function automatic longint sat_sum(input longint a, input longint b, inout bit sat);
    longint s;
    s = a + b;
    if (s > ENTRY_MAX) begin
      s = ENTRY_MAX;
      sat = 1'b1;
    end
    if (s < ENTRY_MIN) begin
      s = ENTRY_MIN;
      sat = 1'b1;
    end
    return s;
  endfunction

  function automatic void accumulate(input int row, input int col, input longint re,
                                     input longint im, inout bit sat);
    int idx;
    idx = row * BUSES + col;
    g_store[idx] = sat_sum(g_store[idx], re, sat);
    b_store[idx] = sat_sum(b_store[idx], im, sat);
  endfunction

  function automatic bit bus_in_range(input logic [6:0] bus);
    return bus >= 1 && bus <= BUSES;
  endfunction

  function automatic void clear_matrix();
    foreach (g_store[k]) begin
      g_store[k] = 0;
      b_store[k] = 0;
    end
  endfunction

  // expected result of one beat; updates the predicted matrix
  function automatic entry_beat_t predict_beat();
    entry_beat_t res;
    bit sat;
    longint rl, xl, bl, xm, g, b, ysi, orr, oim;
    longint unsigned d, tt, t2;
    int i, j;
    res.re = '0;
    res.im = '0;
    res.st = ST_OK;
    sat = 1'b0;
    case (mode_e'(mode_q))
      MODE_ADD: begin
        rl = longint'(resistance_q);
        xl = longint'(reactance_q);
        bl = longint'(shunt_q);
        if (!bus_in_range(from_bus_q) || !bus_in_range(to_bus_q)) begin
          res.st = ST_RANGE;
        end else if (rl == 0 && xl == 0) begin
          res.st = ST_ZERO;
        end else begin
          xm = (xl < 0) ? -xl : xl;
          d = rl * rl + xm * xm;
          tt = (tap_q == 0) ? (64'd1 << FRAC) : longint'(tap_q);
          t2 = tt * tt;
          i = from_bus_q - 1;
          j = to_bus_q - 1;
          // series admittance y = g + jb, then y + jB on the shunt side
          g = longint'(scaled_quot(rl, 2 * FRAC, d, sat));
          b = signed_quot(-xl, 2 * FRAC, d, sat);
          ysi = clamp_cap(b + bl, sat);
          accumulate(i, i, signed_quot(g, 2 * FRAC, t2, sat),
                     signed_quot(ysi, 2 * FRAC, t2, sat), sat);
          orr = -signed_quot(g, FRAC, tt, sat);
          oim = -signed_quot(b, FRAC, tt, sat);
          accumulate(i, j, orr, oim, sat);
          accumulate(j, i, orr, oim, sat);
          accumulate(j, j, g, ysi, sat);
          res.st = sat ? ST_SAT : ST_OK;
        end
      end
      MODE_READ: begin
        if (!bus_in_range(row_bus_q) || !bus_in_range(col_bus_q)) begin
          res.st = ST_RANGE;
        end else begin
          res.re = 40'(g_store[(row_bus_q - 1) * BUSES + (col_bus_q - 1)]);
          res.im = 40'(b_store[(row_bus_q - 1) * BUSES + (col_bus_q - 1)]);
        end
      end
      MODE_CLEAR: clear_matrix();
      default: ;
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus: one beat per call, valid left high after acceptance so the next
  // call can keep it high without a second assignment in the same step
  // ---------------------------------------------------------------------------
  task automatic send_beat(input mode_e mode, input logic [6:0] fb, input logic [6:0] tob,
                           input logic [23:0] r, input logic [23:0] x, input logic [23:0] bsh,
                           input logic [21:0] t, input logic [6:0] rb, input logic [6:0] cb);
    entry_beat_t res;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      // junk on the idle payload
      resistance_q <= 24'($urandom);
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid     <= 1'b1;
    mode_q       <= mode;
    from_bus_q   <= fb;
    to_bus_q     <= tob;
    resistance_q <= r;
    reactance_q  <= x;
    shunt_q      <= bsh;
    tap_q        <= t;
    row_bus_q    <= rb;
    col_bus_q    <= cb;
    do @(posedge clk); while (in_stall);
    // beat taken at this edge
    res = predict_beat();
    pending_results.insert(pending_results.size(), res);
    case (mode)
      MODE_ADD:   n_adds++;
      MODE_READ:  n_reads++;
      MODE_CLEAR: n_clears++;
      default:    n_other++;
    endcase
  endtask

  task automatic add_branch(input logic [6:0] fb, input logic [6:0] tob, input logic [23:0] r,
                            input logic [23:0] x, input logic [23:0] bsh, input logic [21:0] t);
    send_beat(MODE_ADD, fb, tob, r, x, bsh, t, 7'($urandom), 7'($urandom));
  endtask

  task automatic read_entry(input logic [6:0] rb, input logic [6:0] cb);
    send_beat(MODE_READ, 7'($urandom), 7'($urandom), 24'($urandom), 24'($urandom),
              24'($urandom), 22'($urandom), rb, cb);
  endtask

  task automatic clear_all();
    send_beat(MODE_CLEAR, 7'($urandom), 7'($urandom), 24'($urandom), 24'($urandom),
              24'($urandom), 22'($urandom), 7'($urandom), 7'($urandom));
  endtask

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    entry_beat_t exp_res;
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: real %0d imag %0d status %0d",
               real_part, imag_part, status);
        errors++;
      end else begin
        exp_res = pending_results.pop_front();
        n_checked++;
        if (exp_res.st == ST_SAT) n_sat++;
        if (real_part !== exp_res.re) begin
          $error("real_part expected %0d got %0d", exp_res.re, real_part);
          errors++;
        end
        if (imag_part !== exp_res.im) begin
          $error("imag_part expected %0d got %0d", exp_res.im, imag_part);
          errors++;
        end
        if (status !== exp_res.st) begin
          $error("status expected %0d got %0d", exp_res.st, status);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // test tasks
  // ---------------------------------------------------------------------------

  // store comes out of reset cleared
  task automatic test_reset_state();
    read_entry(7'd1, 7'd1);
    read_entry(7'd64, 7'd64);
    read_entry(7'd64, 7'd1);
  endtask

  // bus numbers 0 and above the bus count, add and read side
  task automatic test_bus_range();
    add_branch(7'd0, 7'd2, 24'h010000, 24'h020000, 24'h001000, 22'd0);
    add_branch(7'd3, 7'd65, 24'h010000, 24'h020000, 24'h001000, 22'd0);
    add_branch(7'd127, 7'd127, 24'h010000, 24'h020000, 24'h001000, 22'd0);
    read_entry(7'd0, 7'd1);
    read_entry(7'd1, 7'd65);
    read_entry(7'd127, 7'd127);
  endtask

  task automatic test_zero_impedance();
    add_branch(7'd1, 7'd2, 24'd0, 24'd0, 24'h7FFFFF, 22'h3FFFFF);
    read_entry(7'd1, 7'd1);
  endtask

  task automatic test_unused_mode();
    send_beat(MODE_NONE, 7'd1, 7'd2, 24'hFFFFFF, 24'h800000, 24'h7FFFFF, 22'h3FFFFF,
              7'd1, 7'd1);
  endtask

  // plain branch at unity tap, a transformer and a same-bus branch
  task automatic test_branches();
    add_branch(7'd1, 7'd2, 24'h002000, 24'h010000, 24'h000800, 22'd0);
    add_branch(7'd2, 7'd3, 24'h001000, 24'hFF0000, 24'hFFF000, 22'h0F0000);
    add_branch(7'd4, 7'd4, 24'h004000, 24'h008000, 24'h000400, 22'h110000);
    read_entry(7'd1, 7'd1);
    read_entry(7'd1, 7'd2);
    read_entry(7'd2, 7'd1);
    read_entry(7'd4, 7'd4);
  endtask

  // field extremes, and the tiny impedance / tiny tap that clamp and saturate
  task automatic test_extremes();
    add_branch(7'd64, 7'd63, 24'hFFFFFF, 24'h800000, 24'h7FFFFF, 22'h3FFFFF);
    add_branch(7'd63, 7'd64, 24'd0, 24'h7FFFFF, 24'h800000, 22'd1);
    add_branch(7'd5, 7'd6, 24'd1, 24'd0, 24'd0, 22'd1);
    add_branch(7'd6, 7'd5, 24'd0, 24'hFFFFFF, 24'h7FFFFF, 22'd0);
    read_entry(7'd64, 7'd64);
    read_entry(7'd5, 7'd5);
    read_entry(7'd6, 7'd5);
  endtask

  task automatic test_clear();
    clear_all();
    read_entry(7'd5, 7'd5);
    read_entry(7'd1, 7'd2);
  endtask

  function automatic logic [23:0] pick_resistance();
    case ($urandom_range(3))
      0: return 24'($urandom);
      1: return 24'($urandom_range(32'h1000, 32'h40000));
      2: return 24'd0;
      default: return 24'($urandom_range(32'h40));
    endcase
  endfunction

  function automatic logic [23:0] pick_signed24();
    case ($urandom_range(3))
      0: return 24'($urandom);
      1: return 24'($urandom_range(32'h80000));
      2: return 24'(-$urandom_range(32'h80000));
      default: return 24'($urandom_range(32'h40) - 32'h20);
    endcase
  endfunction

  function automatic logic [21:0] pick_tap();
    case ($urandom_range(3))
      0: return 22'd0;
      1: return 22'((32'd1 << FRAC) + $urandom_range(32'h20000) - 32'h10000);
      2: return 22'($urandom);
      default: return 22'($urandom_range(32'h100));
    endcase
  endfunction

  // buses mostly from a small set so reads hit built-up entries
  function automatic logic [6:0] pick_bus();
    case ($urandom_range(9))
      0: return 7'($urandom);
      1: return 7'($urandom_range(BUSES));
      default: return 7'($urandom_range(1, 8));
    endcase
  endfunction

  // mostly adds and reads on valid buses, some noise, rare clears
  task automatic test_random(input int unsigned items);
    int unsigned pick;
    for (int unsigned n = 0; n < items; n++) begin
      pick = $urandom_range(199);
      if (pick < 110)
        add_branch(pick_bus(), pick_bus(), pick_resistance(), pick_signed24(),
                   pick_signed24(), pick_tap());
      else if (pick < 190)
        read_entry(pick_bus(), pick_bus());
      else if (pick < 197)
        send_beat(MODE_NONE, 7'($urandom), 7'($urandom), 24'($urandom), 24'($urandom),
                  24'($urandom), 22'($urandom), 7'($urandom), 7'($urandom));
      else
        clear_all();
    end
  endtask

  initial begin
    clear_matrix();
    repeat (8) @(posedge clk);
    rst_ni <= 1'b1;

    // directed part, no idling on either side
    test_reset_state();
    test_bus_range();
    test_zero_impedance();
    test_unused_mode();
    test_branches();
    test_extremes();
    test_clear();

    // random part in three idling phases
    send_idle_pct = 32;
    recv_idle_pct = 80;
    test_random(260);
    send_idle_pct = 80;
    recv_idle_pct = 32;
    test_random(260);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(280);

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("covered %0d adds, %0d reads, %0d clears, %0d unused-mode beats",
             n_adds, n_reads, n_clears, n_other);
    $display("checked %0d result beats, %0d of them saturated", n_checked, n_sat);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
